### hdl/sorted_key_set_macros.svh
// Assertion helpers used by sorted_key_set. Both expect clk and rst_n in scope.
`ifndef SORTED_KEY_SET_MACROS_SVH
`define SORTED_KEY_SET_MACROS_SVH

// Same-cycle implication.
`define SKSET_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_key_set: same-cycle check failed");

// Next-cycle implication.
`define SKSET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_key_set: next-cycle check failed");

`endif

### hdl/skset_pkg.sv
package skset_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 8;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_REMOVE = 3'd1,
    FN_MEMBER = 3'd2,
    FN_FIRST  = 3'd3,
    FN_NEXT   = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } skset_ctl_t;

endpackage

### hdl/skset_if.sv
interface skset_in_if;
  import skset_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic signed [KEY_W-1:0] key;
  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface skset_out_if;
  import skset_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic signed [KEY_W-1:0] key_out;
  logic [ECNT_W-1:0]   entry_count;
  modport source (output valid, output status, output key_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input key_out, input entry_count,
                  output ready);
endinterface

### hdl/sorted_key_set.sv
// sorted_key_set: ascending set of distinct signed keys in a row of cells.
// Result: registered, valid in the cycle after the word is accepted.
// Throughput: one word per cycle; all cells compare and shift in parallel,
// the result register holds one word and frees when the sink takes it.
// Reset (rst_n, synchronous, active low): set empty, cursor cleared, no result;
// cell contents are not cleared, occupancy comes from the key count.
`include "sorted_key_set_macros.svh"
module sorted_key_set (
  input  logic clk,
  input  logic rst_n,
  skset_in_if.sink    in_ch,
  skset_out_if.source out_ch
);
  import skset_pkg::*;

  // state
  logic [CNT_W-1:0] count_r, count_nxt;
  key_t             cur_key_r, cur_key_nxt;
  logic             cur_vld_r, cur_vld_nxt;

  // result register
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  key_t              key_out_r, key_out_nxt;

  logic       accept;
  skset_ctl_t ctl;

  // per-cell signals
  key_t cell_key [CAPACITY];
  logic [CAPACITY-1:0] occ, lt, le, eq, sel;

  logic found, full, nxt_hit;
  key_t nxt_key;

  // result slot frees as the sink takes the pending word
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full = (count_r >= CNT_W'(CAPACITY));

  // the row of cells; cell 0 sees a virtual left neighbor below every key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);
    skset_cell u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .key_i       (in_ch.key),
      .cursor_i    (cur_key_r),
      .occ_i       (occ[i]),
      .left_lt_i   ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .left_key_i  (cell_key[(i == 0) ? 0 : i-1]),
      .right_key_i (cell_key[(i == CAPACITY-1) ? i : i+1]),
      .key_o       (cell_key[i]),
      .lt_o        (lt[i]),
      .le_o        (le[i]),
      .eq_o        (eq[i])
    );
    // first occupied cell above the cursor: le falls from 1 to 0 here
    assign sel[i] = occ[i] && !le[i] && ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i-1]);
  end

  assign found   = |eq;
  assign nxt_hit = |sel;

  // one-hot select of the next key
  always_comb begin
    nxt_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) nxt_key = nxt_key | cell_key[i];
    end
  end

  // request decode
  always_comb begin
    count_nxt   = count_r;
    cur_key_nxt = cur_key_r;
    cur_vld_nxt = cur_vld_r;
    status_nxt  = ST_MISS;
    key_out_nxt = '0;
    ctl         = '0;
    unique case (in_ch.func)
      FN_INSERT: begin
        if (found) begin
          status_nxt = ST_MISS;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_OK;
          ctl.ins    = accept;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (found) begin
          status_nxt = ST_OK;
          ctl.rem    = accept;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      FN_MEMBER: begin
        status_nxt = found ? ST_OK : ST_MISS;
      end
      FN_FIRST: begin
        if (occ[0]) begin
          status_nxt  = ST_OK;
          key_out_nxt = cell_key[0];
          cur_key_nxt = cell_key[0];
          cur_vld_nxt = 1'b1;
        end else begin
          cur_vld_nxt = 1'b0;
        end
      end
      FN_NEXT: begin
        if (cur_vld_r) begin
          if (nxt_hit) begin
            status_nxt  = ST_OK;
            key_out_nxt = nxt_key;
            cur_key_nxt = nxt_key;
          end else begin
            cur_vld_nxt = 1'b0;
          end
        end
      end
      default: ;  // unused codes: no change, miss
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_key_r   <= '0;
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        cur_key_r   <= cur_key_nxt;
        cur_vld_r   <= cur_vld_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      key_out_r <= key_out_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.key_out     = key_out_r;
  assign out_ch.entry_count = ECNT_W'(count_r);

  // checks
  `SKSET_ASSERT_IMPL(a_count_cap, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SKSET_ASSERT_NEXT(a_ins_grows, ctl.ins, count_r == $past(count_r) + CNT_W'(1))
  `SKSET_ASSERT_IMPL(a_full_at_cap, out_valid_r && (status_r == ST_FULL),
                     count_r == CNT_W'(CAPACITY))
  `SKSET_ASSERT_NEXT(a_first_empty, accept && (in_ch.func == FN_FIRST) && !occ[0],
                     !cur_vld_r)

endmodule

### hdl/skset_cell.sv
// One slot of the sorted row. Shifts up on insert, down on remove.
module skset_cell (
  input  logic                clk,
  input  skset_pkg::skset_ctl_t ctl_i,
  input  skset_pkg::key_t     key_i,
  input  skset_pkg::key_t     cursor_i,
  input  logic                occ_i,
  input  logic                left_lt_i,
  input  skset_pkg::key_t     left_key_i,
  input  skset_pkg::key_t     right_key_i,
  output skset_pkg::key_t     key_o,
  output logic                lt_o,
  output logic                le_o,
  output logic                eq_o
);
  import skset_pkg::*;

  key_t key_r;
  key_t key_nxt;

  assign lt_o  = occ_i && (key_r < key_i);
  assign le_o  = occ_i && (key_r <= cursor_i);
  assign eq_o  = occ_i && (key_r == key_i);
  assign key_o = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl_i.ins) begin
      if (!left_lt_i) key_nxt = left_key_i;   // above insert point
      else if (!lt_o) key_nxt = key_i;         // the insert point
    end else if (ctl_i.rem) begin
      if (!lt_o) key_nxt = right_key_i;        // at or above removed key
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import skset_pkg::*;

  // Codes the block does not define; it must answer them as a miss and keep its state.
  localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

  localparam int RANDOM_WORDS = 930;
  localparam int CALM_TAIL    = 120;   // last words of the run go without idling
  localparam int HOLD_AT      = 300;   // word count that starts the long sink hold-off
  localparam int HOLD_CYCLES  = 80;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    key_t              key;
  } set_request_t;

  typedef struct {
    status_t           status;
    key_t              key_out;
    logic [ECNT_W-1:0] count;
  } set_answer_t;

  logic clk;
  logic rst_n;

  skset_in_if  in_ch ();
  skset_out_if out_ch ();

  sorted_key_set dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Words still to be offered, and answers the block owes, oldest first.
  set_request_t pending_requests[$];
  set_answer_t  expected_answers[$];

  int accepted_cnt;   // words taken by the block; counted up with <= in the driver
  int total_items;
  int fail_cnt;

  // Shadow copy of the set, kept in ascending order in slots 0..held_n-1.
  key_t held_keys[CAPACITY];
  int   held_n;
  key_t cursor;
  bit   cursor_on;

  // Pool of keys that the random part draws from, so hits and a full set are common.
  int pool_lo;
  int pool_span;

  // Applies one request to the shadow set and returns the answer it must give.
  function automatic set_answer_t apply_set_op(logic [FUNC_W-1:0] fn, key_t k);
    set_answer_t ans;
    int          pos;
    int          nxt;
    bit          hit;
    ans.status  = ST_MISS;
    ans.key_out = '0;
    pos = 0;
    while (pos < held_n && held_keys[pos] < k) pos++;
    hit = (pos < held_n) && (held_keys[pos] == k);
    case (fn)
      FN_INSERT: begin
        // a duplicate wins over full
        if (hit) begin
          ans.status = ST_MISS;
        end else if (held_n >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = held_n; i > pos; i--) held_keys[i] = held_keys[i-1];
          held_keys[pos] = k;
          held_n++;
          ans.status = ST_OK;
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          for (int i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i+1];
          held_n--;
          ans.status = ST_OK;
        end
      end
      FN_MEMBER: ans.status = hit ? ST_OK : ST_MISS;
      FN_FIRST: begin
        if (held_n > 0) begin
          ans.key_out = held_keys[0];
          cursor      = held_keys[0];
          cursor_on   = 1'b1;
          ans.status  = ST_OK;
        end else begin
          cursor_on = 1'b0;
        end
      end
      FN_NEXT: begin
        // cursor is a key value, so a removed cursor key still finds its successor
        if (cursor_on) begin
          nxt = 0;
          while (nxt < held_n && held_keys[nxt] <= cursor) nxt++;
          if (nxt < held_n) begin
            ans.key_out = held_keys[nxt];
            cursor      = held_keys[nxt];
            ans.status  = ST_OK;
          end else begin
            cursor_on = 1'b0;
          end
        end
      end
      default: ;
    endcase
    ans.count = ECNT_W'(held_n);
    return ans;
  endfunction

  task automatic add_req(logic [FUNC_W-1:0] fn, key_t k);
    set_request_t r;
    r.fn  = fn;
    r.key = k;
    pending_requests.push_back(r);
  endtask

  function automatic key_t pool_key();
    return key_t'(pool_lo + int'($urandom_range(0, pool_span - 1)));
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic add_directed();
    add_req(FN_MEMBER, 8'sd0);       // empty set: not held
    add_req(FN_FIRST, 8'sd0);        // fetch first on empty set
    add_req(FN_NEXT, 8'sd0);         // fetch next with no cursor
    add_req(FN_REMOVE, 8'sd5);       // remove of an absent key
    add_req(FN_INSERT, -8'sd128);
    add_req(FN_INSERT, 8'sd127);
    add_req(FN_INSERT, 8'sd0);
    add_req(FN_INSERT, -8'sd1);
    add_req(FN_INSERT, 8'sd127);     // duplicate
    add_req(FN_MEMBER, -8'sd128);
    add_req(FN_MEMBER, 8'sd1);
    add_req(FN_FIRST, 8'sd127);      // key is ignored here
    add_req(FN_NEXT, -8'sd128);
    add_req(FN_NEXT, 8'sd0);
    add_req(FN_NEXT, 8'sd0);
    add_req(FN_NEXT, 8'sd0);         // past the last key: cursor drops
    add_req(FN_NEXT, 8'sd0);         // still no cursor
    add_req(FN_RSVD5, 8'sd127);
    add_req(FN_RSVD6, -8'sd128);
    add_req(FN_RSVD7, -8'sd1);
    add_req(FN_FIRST, 8'sd0);
    add_req(FN_REMOVE, -8'sd128);    // cursor key removed under the cursor
    add_req(FN_NEXT, 8'sd0);         // expects -1, the smallest key above -128
    add_req(FN_REMOVE, 8'sd0);
  endtask

  task automatic add_random();
    int n;
    while (pending_requests.size() < total_items) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          // fill: the pool is often wider than capacity, so the set often runs full
          n = $urandom_range(8, 24);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) add_req(FN_MEMBER, pool_key());
            else add_req(FN_INSERT, pool_key());
          end
        end
        6, 7, 8, 9: begin
          n = $urandom_range(4, 16);
          repeat (n) begin
            if ($urandom_range(0, 3) == 0) add_req(FN_MEMBER, pool_key());
            else add_req(FN_REMOVE, pool_key());
          end
        end
        10, 11, 12, 13, 14: begin
          // walk the set, sometimes editing it under the cursor
          add_req(FN_FIRST, key_t'($urandom));
          n = $urandom_range(1, 20);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0: add_req(FN_REMOVE, pool_key());
              1: add_req(FN_INSERT, pool_key());
              default: add_req(FN_NEXT, key_t'($urandom));
            endcase
          end
        end
        15, 16: begin
          n = $urandom_range(3, 10);
          repeat (n) add_req(logic'($urandom_range(0, 7)) ? FUNC_W'($urandom_range(0, 7))
                                                           : FUNC_W'($urandom_range(0, 7)),
                             key_t'($urandom));
        end
        default: begin
          // sweep the old pool out, then move it; the ends of the key range get extra weight
          for (int v = pool_lo; v < pool_lo + pool_span; v++) add_req(FN_REMOVE, key_t'(v));
          pool_span = $urandom_range(4, 40);
          case ($urandom_range(0, 3))
            0: pool_lo = -128;
            1: pool_lo = 128 - pool_span;
            default: pool_lo = int'($urandom_range(0, 256 - pool_span)) - 128;
          endcase
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- clock, reset, end
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = '0;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    accepted_cnt = 0;
    fail_cnt     = 0;
    held_n       = 0;
    cursor       = '0;
    cursor_on    = 1'b0;
    pool_lo      = -20;
    pool_span    = 24;
    add_directed();
    total_items = pending_requests.size() + RANDOM_WORDS;
    add_random();
    total_items = pending_requests.size();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (accepted_cnt < total_items || expected_answers.size() != 0) @(posedge clk);
    // answers are registered; the wait below lets any extra word still show up
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout at %0t", $time);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- driver
  int           send_gap;
  int           send_idle_pct;
  set_request_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.func    <= '0;
      in_ch.key     <= '0;
      send_gap      = 0;
      send_idle_pct = 10;
    end else begin
      // predict on acceptance, so the answer is queued before it can appear
      if (in_ch.valid && in_ch.ready) begin
        expected_answers.push_back(apply_set_op(in_ch.func, in_ch.key));
        accepted_cnt <= accepted_cnt + 1;
      end
      // a word that was not taken stays on the bus unchanged
      if (!in_ch.valid || in_ch.ready) begin
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 8;
            default: send_idle_pct = 30;
          endcase
        end
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (accepted_cnt < total_items - CALM_TAIL &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 16);   // start an idle burst, its length drawn into send_gap
          in_ch.valid <= 1'b0;
        end else begin
          next_req = pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func  <= next_req.fn;
          in_ch.key   <= next_req.key;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sink ready
  int stall_left;
  int stall_pct;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
      stall_pct    = 10;
      hold_left    = 0;
      hold_done    = 1'b0;
    end else begin
      // one long hold-off mid-run: the result register fills and input ready must drop
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (accepted_cnt < total_items - CALM_TAIL &&
                   $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  set_answer_t want;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected word: status %0d key_out %0d count %0d", $time,
                 out_ch.status, out_ch.key_out, out_ch.entry_count);
        fail_cnt++;
      end else begin
        want = expected_answers.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_ch.status);
          fail_cnt++;
        end
        if (out_ch.key_out !== want.key_out) begin
          $display("%0t: key_out expected %0d, got %0d", $time, want.key_out, out_ch.key_out);
          fail_cnt++;
        end
        if (out_ch.entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, want.count,
                   out_ch.entry_count);
          fail_cnt++;
        end
      end
    end
  end

endmodule
